// File: src/va3_pkg.sv
// Shared constants, widths and the arctangent table for the vector angle block.
`timescale 1ns / 1ps
package va3_pkg;

    localparam int MAG_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int COS_FRAC = 30;
    localparam int DEG_FRAC = 24;
    localparam int XY_W     = 33;
    localparam int Z_W      = 32;
    localparam int SIDE_W   = 2;

    // Elementary rotation angles atan(2^-i), in units of 2^-24 degree.
    function automatic logic [31:0] va3_atan_q24(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd754974720;
            1:  v = 32'd445687602;
            2:  v = 32'd235489088;
            3:  v = 32'd119537938;
            4:  v = 32'd60000934;
            5:  v = 32'd30029717;
            6:  v = 32'd15018523;
            7:  v = 32'd7509720;
            8:  v = 32'd3754917;
            9:  v = 32'd1877466;
            10: v = 32'd938734;
            11: v = 32'd469367;
            12: v = 32'd234684;
            13: v = 32'd117342;
            14: v = 32'd58671;
            15: v = 32'd29335;
            16: v = 32'd14668;
            17: v = 32'd7334;
            18: v = 32'd3667;
            19: v = 32'd1833;
            20: v = 32'd917;
            21: v = 32'd458;
            22: v = 32'd229;
            23: v = 32'd115;
            24: v = 32'd57;
            25: v = 32'd29;
            26: v = 32'd14;
            27: v = 32'd7;
            28: v = 32'd4;
            29: v = 32'd2;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/va3_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps
module va3_sqrt_cell
    import va3_pkg::*;
#(
    parameter int J  = 31,
    parameter int SW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [MAG_W-1:0] in_n,
    input  logic [MAG_W-1:0] in_r,
    input  logic [SW-1:0]    in_side,
    output logic             out_vld,
    output logic [MAG_W-1:0] out_n,
    output logic [MAG_W-1:0] out_r,
    output logic [SW-1:0]    out_side
);

    localparam logic [MAG_W-1:0] BIT = MAG_W'(1) << (2 * J);

    logic [MAG_W-1:0] t;
    logic [MAG_W-1:0] n_next;
    logic [MAG_W-1:0] r_next;
    logic             vld_reg;
    logic [MAG_W-1:0] n_reg;
    logic [MAG_W-1:0] r_reg;
    logic [SW-1:0]    side_reg;

    always_comb
    begin
        t = in_r + BIT;
        if (in_n >= t)
        begin
            n_next = in_n - t;
            r_next = (in_r >> 1) + BIT;
        end
        else
        begin
            n_next = in_n;
            r_next = in_r >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_n    = n_reg;
    assign out_r    = r_reg;
    assign out_side = side_reg;

endmodule

// File: src/va3_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider.
`timescale 1ns / 1ps
module va3_div_cell
    import va3_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [ROOT_W-1:0] in_rem,
    input  logic [ROOT_W-1:0] in_div,
    input  logic [ROOT_W-1:0] in_num,
    input  logic [ROOT_W-1:0] in_q,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [ROOT_W-1:0] out_rem,
    output logic [ROOT_W-1:0] out_div,
    output logic [ROOT_W-1:0] out_num,
    output logic [ROOT_W-1:0] out_q,
    output logic [SIDE_W-1:0] out_side
);

    localparam int B = ROOT_W - 1 - K;

    logic [ROOT_W:0]   t;
    logic [ROOT_W:0]   diff;
    logic [ROOT_W-1:0] rem_next;
    logic [ROOT_W-1:0] q_next;
    logic              vld_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [ROOT_W-1:0] div_reg;
    logic [ROOT_W-1:0] num_reg;
    logic [ROOT_W-1:0] q_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        t      = {in_rem, in_num[B]};
        diff   = t - {1'b0, in_div};
        q_next = in_q;
        if (t >= {1'b0, in_div})
        begin
            rem_next  = diff[ROOT_W-1:0];
            q_next[B] = 1'b1;
        end
        else
        begin
            rem_next = t[ROOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            num_reg  <= in_num;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_div  = div_reg;
    assign out_num  = num_reg;
    assign out_q    = q_reg;
    assign out_side = side_reg;

endmodule

// File: src/va3_cordic_cell.sv
// One rotation cell of the vectoring CORDIC that yields the arc cosine.
`timescale 1ns / 1ps
module va3_cordic_cell
    import va3_pkg::*;
#(
    parameter int I = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic signed [XY_W-1:0] in_x,
    input  logic signed [XY_W-1:0] in_y,
    input  logic signed [Z_W-1:0]  in_z,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_vld,
    output logic signed [XY_W-1:0] out_x,
    output logic signed [XY_W-1:0] out_y,
    output logic signed [Z_W-1:0]  out_z,
    output logic [SIDE_W-1:0]      out_side
);

    localparam logic signed [Z_W-1:0] ANG = $signed(va3_atan_q24(I));

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;
    logic                   vld_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [SIDE_W-1:0]      side_reg;

    always_comb
    begin
        dx = in_y >>> I;
        dy = in_x >>> I;
        if (in_y > 0)
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ANG;
        end
        else
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_x    = x_reg;
    assign out_y    = y_reg;
    assign out_z    = z_reg;
    assign out_side = side_reg;

endmodule

// File: src/vector_angle_3d_degrees.sv
// Top level of the 3-D vector angle block: products, roots, divider, CORDIC, output skid.
`timescale 1ns / 1ps
// One vector pair enters per clock while in_ready is high. Each pair passes through one cell
// per root digit for both magnitude roots (32 cells) and the sine root (31 cells), one cell
// per quotient bit of the cosine divider (32 cells), one cell per CORDIC rotation, plus
// product, sum, normalize and rounding stages.
// A two-word output buffer lets the pipeline keep accepting while a finished word waits;
// in_ready drops only when both output words are held.
module vector_angle_3d_degrees
    import va3_pkg::*;
#(
    parameter int COMPONENT_BITS  = 16,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int ACOS_STAGES     = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COMPONENT_BITS-1:0] a_x,
    input  logic signed [COMPONENT_BITS-1:0] a_y,
    input  logic signed [COMPONENT_BITS-1:0] a_z,
    input  logic signed [COMPONENT_BITS-1:0] b_x,
    input  logic signed [COMPONENT_BITS-1:0] b_y,
    input  logic signed [COMPONENT_BITS-1:0] b_z,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [15:0]                      angle_deg,
    output logic                             zero_vector
);

    localparam int CB      = COMPONENT_BITS;
    localparam int PW      = 2 * CB;
    localparam int OSH     = DEG_FRAC - ANGLE_FRAC_BITS;
    localparam int SA_W    = MAG_W + 1 + 6;
    localparam int SS_W    = COS_FRAC + 1 + SIDE_W;
    localparam int ANG_MAX = ((180 << ANGLE_FRAC_BITS) > 65535) ? 65535
                           : (180 << ANGLE_FRAC_BITS);
    localparam logic signed [Z_W-1:0] Z_90 = Z_W'(90 << DEG_FRAC);
    localparam logic [31:0] THETA_180 = 32'(64'd180 << DEG_FRAC);

    logic en;
    assign en = in_ready;

    // Stage 1: magnitudes and the nine products.
    logic signed [CB-1:0] va [0:2];
    logic signed [CB-1:0] vb [0:2];
    logic [CB-1:0]        ua [0:2];
    logic [CB-1:0]        ub [0:2];
    logic [PW-1:0]        sqa_reg [0:2];
    logic [PW-1:0]        sqb_reg [0:2];
    logic [PW-1:0]        pr_reg  [0:2];
    logic [2:0]           ngs_reg;
    logic                 v1_reg;

    assign va[0] = a_x;
    assign va[1] = a_y;
    assign va[2] = a_z;
    assign vb[0] = b_x;
    assign vb[1] = b_y;
    assign vb[2] = b_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ua[i] = va[i][CB-1] ? CB'(-va[i]) : CB'(va[i]);
            ub[i] = vb[i][CB-1] ? CB'(-vb[i]) : CB'(vb[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sqa_reg[i] <= PW'(ua[i]) * PW'(ua[i]);
                sqb_reg[i] <= PW'(ub[i]) * PW'(ub[i]);
                pr_reg[i]  <= PW'(ua[i]) * PW'(ub[i]);
                ngs_reg[i] <= va[i][CB-1] ^ vb[i][CB-1];
            end
        end
    end

    // Stage 2: sums, signed dot product split into magnitude and sign.
    logic [MAG_W-1:0] ma_c;
    logic [MAG_W-1:0] mb_c;
    logic [MAG_W-1:0] pos_c;
    logic [MAG_W-1:0] negs_c;
    logic [MAG_W-1:0] ma2_reg;
    logic [MAG_W-1:0] mb2_reg;
    logic [MAG_W-1:0] dm2_reg;
    logic             neg2_reg;
    logic             zero2_reg;
    logic             v2_reg;

    always_comb
    begin
        ma_c   = '0;
        mb_c   = '0;
        pos_c  = '0;
        negs_c = '0;
        for (int i = 0; i < 3; i++)
        begin
            ma_c = ma_c + MAG_W'(sqa_reg[i]);
            mb_c = mb_c + MAG_W'(sqb_reg[i]);
            if (ngs_reg[i])
            begin
                negs_c = negs_c + MAG_W'(pr_reg[i]);
            end
            else
            begin
                pos_c = pos_c + MAG_W'(pr_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma2_reg   <= ma_c;
            mb2_reg   <= mb_c;
            neg2_reg  <= pos_c < negs_c;
            dm2_reg   <= (pos_c >= negs_c) ? pos_c - negs_c : negs_c - pos_c;
            zero2_reg <= (ma_c == '0) || (mb_c == '0);
        end
    end

    // Normalize both squared magnitudes by even shifts, coarse to fine.
    logic [MAG_W-1:0] nm_a [0:5];
    logic [MAG_W-1:0] nm_b [0:5];
    logic [4:0]       nk_a [0:5];
    logic [4:0]       nk_b [0:5];
    logic [MAG_W-1:0] nm_dm [0:5];
    logic [SIDE_W-1:0] nm_sd [0:5];
    logic             nm_v [0:5];

    assign nm_a[0]  = ma2_reg;
    assign nm_b[0]  = mb2_reg;
    assign nk_a[0]  = '0;
    assign nk_b[0]  = '0;
    assign nm_dm[0] = dm2_reg;
    assign nm_sd[0] = {neg2_reg, zero2_reg};
    assign nm_v[0]  = v2_reg;

    for (genvar g = 0; g < 5; g++)
    begin : g_norm
        localparam int T = 32 >> g;
        localparam logic [4:0] KI = 5'(T / 2);
        logic [MAG_W-1:0]  a_reg;
        logic [MAG_W-1:0]  b_reg;
        logic [4:0]        ka_reg;
        logic [4:0]        kb_reg;
        logic [MAG_W-1:0]  dm_reg;
        logic [SIDE_W-1:0] sd_reg;
        logic              v_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= nm_v[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (nm_a[g][MAG_W-1 -: T] == '0)
                begin
                    a_reg  <= nm_a[g] << T;
                    ka_reg <= nk_a[g] + KI;
                end
                else
                begin
                    a_reg  <= nm_a[g];
                    ka_reg <= nk_a[g];
                end
                if (nm_b[g][MAG_W-1 -: T] == '0)
                begin
                    b_reg  <= nm_b[g] << T;
                    kb_reg <= nk_b[g] + KI;
                end
                else
                begin
                    b_reg  <= nm_b[g];
                    kb_reg <= nk_b[g];
                end
                dm_reg <= nm_dm[g];
                sd_reg <= nm_sd[g];
            end
        end

        assign nm_a[g+1]  = a_reg;
        assign nm_b[g+1]  = b_reg;
        assign nk_a[g+1]  = ka_reg;
        assign nk_b[g+1]  = kb_reg;
        assign nm_dm[g+1] = dm_reg;
        assign nm_sd[g+1] = sd_reg;
        assign nm_v[g+1]  = v_reg;
    end

    // Magnitude roots; chain a carries the dot product, zero flag and total shift.
    logic [MAG_W-1:0] ra_n [0:32];
    logic [MAG_W-1:0] ra_r [0:32];
    logic [SA_W-1:0]  ra_s [0:32];
    logic             ra_v [0:32];
    logic [MAG_W-1:0] rb_n [0:32];
    logic [MAG_W-1:0] rb_r [0:32];
    logic [0:0]       rb_s [0:32];

    assign ra_n[0] = nm_a[5];
    assign ra_r[0] = '0;
    assign ra_s[0] = {nm_dm[5], nm_sd[5][0], 6'({1'b0, nk_a[5]} + {1'b0, nk_b[5]})};
    assign ra_v[0] = nm_v[5];
    assign rb_n[0] = nm_b[5];
    assign rb_r[0] = '0;
    assign rb_s[0] = nm_sd[5][1];

    for (genvar g = 0; g < 32; g++)
    begin : g_root
        va3_sqrt_cell #(.J(31 - g), .SW(SA_W)) u_ca (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (ra_v[g]),
            .in_n     (ra_n[g]),
            .in_r     (ra_r[g]),
            .in_side  (ra_s[g]),
            .out_vld  (ra_v[g+1]),
            .out_n    (ra_n[g+1]),
            .out_r    (ra_r[g+1]),
            .out_side (ra_s[g+1])
        );
        va3_sqrt_cell #(.J(31 - g), .SW(1)) u_cb (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (ra_v[g]),
            .in_n     (rb_n[g]),
            .in_r     (rb_r[g]),
            .in_side  (rb_s[g]),
            .out_vld  (),
            .out_n    (rb_n[g+1]),
            .out_r    (rb_r[g+1]),
            .out_side (rb_s[g+1])
        );
    end

    // Product of the roots and the dot product scaled by the same shift.
    logic [MAG_W-1:0] dmx;
    logic [5:0]       shx;
    logic [MAG_W-1:0] d_c;
    logic [ROOT_W-1:0] ph_reg;
    logic [ROOT_W-1:0] dh_reg;
    logic [SIDE_W-1:0] sp_reg;
    logic              vp_reg;

    assign dmx = ra_s[32][SA_W-1 -: MAG_W];
    assign shx = ra_s[32][5:0];

    always_comb
    begin
        if ((dmx == '0) || (shx == '0))
        begin
            d_c = dmx;
        end
        else if ((dmx >> (7'd64 - {1'b0, shx})) != '0)
        begin
            d_c = '1;
        end
        else
        begin
            d_c = dmx << shx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg <= 32'((MAG_W'(ra_r[32][ROOT_W-1:0]) * MAG_W'(rb_r[32][ROOT_W-1:0]))
                         >> ROOT_W);
            dh_reg <= d_c[MAG_W-1 -: ROOT_W];
            sp_reg <= {rb_s[32][0], ra_s[32][6]};
        end
    end

    // Cosine divider, one quotient bit per cell.
    logic [ROOT_W-1:0] dv_rem [0:32];
    logic [ROOT_W-1:0] dv_div [0:32];
    logic [ROOT_W-1:0] dv_num [0:32];
    logic [ROOT_W-1:0] dv_q   [0:32];
    logic [SIDE_W-1:0] dv_s   [0:32];
    logic              dv_v   [0:32];

    assign dv_rem[0] = {2'b00, dh_reg[ROOT_W-1:2]};
    assign dv_div[0] = ph_reg;
    assign dv_num[0] = {dh_reg[1:0], 30'd0};
    assign dv_q[0]   = '0;
    assign dv_s[0]   = sp_reg;
    assign dv_v[0]   = vp_reg;

    for (genvar g = 0; g < 32; g++)
    begin : g_div
        va3_div_cell #(.K(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (dv_v[g]),
            .in_rem   (dv_rem[g]),
            .in_div   (dv_div[g]),
            .in_num   (dv_num[g]),
            .in_q     (dv_q[g]),
            .in_side  (dv_s[g]),
            .out_vld  (dv_v[g+1]),
            .out_rem  (dv_rem[g+1]),
            .out_div  (dv_div[g+1]),
            .out_num  (dv_num[g+1]),
            .out_q    (dv_q[g+1]),
            .out_side (dv_s[g+1])
        );
    end

    // Saturate the cosine, square it, form 1 - cos^2.
    localparam logic [ROOT_W-1:0] ONE_Q = ROOT_W'(1) << COS_FRAC;
    logic [COS_FRAC:0]   c1_reg;
    logic [SIDE_W-1:0]   s1c_reg;
    logic                v1c_reg;
    logic [COS_FRAC:0]   c2_reg;
    logic [2*COS_FRAC+1:0] sq2_reg;
    logic [SIDE_W-1:0]   s2c_reg;
    logic                v2c_reg;
    logic [COS_FRAC:0]   c3_reg;
    logic [MAG_W-1:0]    sin3_reg;
    logic [SIDE_W-1:0]   s3c_reg;
    logic                v3c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= (dv_q[32] > ONE_Q) ? ONE_Q[COS_FRAC:0] : dv_q[32][COS_FRAC:0];
            s1c_reg  <= dv_s[32];
            c2_reg   <= c1_reg;
            sq2_reg  <= (2*COS_FRAC+2)'(c1_reg) * (2*COS_FRAC+2)'(c1_reg);
            s2c_reg  <= s1c_reg;
            c3_reg   <= c2_reg;
            sin3_reg <= (MAG_W'(1) << (2 * COS_FRAC)) - MAG_W'(sq2_reg);
            s3c_reg  <= s2c_reg;
        end
    end

    // Sine root; the radicand stays below 4^31, so the top digit cell is left out.
    logic [MAG_W-1:0] sn_n [0:31];
    logic [MAG_W-1:0] sn_r [0:31];
    logic [SS_W-1:0]  sn_s [0:31];
    logic             sn_v [0:31];

    assign sn_n[0] = sin3_reg;
    assign sn_r[0] = '0;
    assign sn_s[0] = {c3_reg, s3c_reg};
    assign sn_v[0] = v3c_reg;

    for (genvar g = 0; g < 31; g++)
    begin : g_sine
        va3_sqrt_cell #(.J(30 - g), .SW(SS_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (sn_v[g]),
            .in_n     (sn_n[g]),
            .in_r     (sn_r[g]),
            .in_side  (sn_s[g]),
            .out_vld  (sn_v[g+1]),
            .out_n    (sn_n[g+1]),
            .out_r    (sn_r[g+1]),
            .out_side (sn_s[g+1])
        );
    end

    // CORDIC vectoring on (|cos|, sin).
    logic signed [XY_W-1:0] cx [0:ACOS_STAGES];
    logic signed [XY_W-1:0] cy [0:ACOS_STAGES];
    logic signed [Z_W-1:0]  cz [0:ACOS_STAGES];
    logic [SIDE_W-1:0]      cs [0:ACOS_STAGES];
    logic                   cv [0:ACOS_STAGES];

    assign cx[0] = $signed(XY_W'(sn_s[31][SS_W-1 -: COS_FRAC+1]));
    assign cy[0] = $signed({1'b0, sn_r[31][ROOT_W-1:0]});
    assign cz[0] = '0;
    assign cs[0] = sn_s[31][SIDE_W-1:0];
    assign cv[0] = sn_v[31];

    for (genvar g = 0; g < ACOS_STAGES; g++)
    begin : g_cordic
        va3_cordic_cell #(.I(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (cv[g]),
            .in_x     (cx[g]),
            .in_y     (cy[g]),
            .in_z     (cz[g]),
            .in_side  (cs[g]),
            .out_vld  (cv[g+1]),
            .out_x    (cx[g+1]),
            .out_y    (cy[g+1]),
            .out_z    (cz[g+1]),
            .out_side (cs[g+1])
        );
    end

    // Clamp, reflect for a negative cosine, round to the output unit.
    logic signed [Z_W-1:0] zc;
    logic [31:0]           theta;
    logic [32:0]           rsum;
    logic [32:0]           rsh;
    logic [15:0]           ang_c;
    logic [15:0]           fin_ang_reg;
    logic                  fin_zero_reg;
    logic                  fin_v_reg;

    always_comb
    begin
        zc = cz[ACOS_STAGES];
        if (zc < 0)
        begin
            zc = '0;
        end
        else if (zc > Z_90)
        begin
            zc = Z_90;
        end
        theta = cs[ACOS_STAGES][1] ? THETA_180 - 32'(zc) : 32'(zc);
        rsum  = {1'b0, theta} + (33'd1 << (OSH - 1));
        rsh   = rsum >> OSH;
        ang_c = (rsh > 33'd65535) ? 16'hFFFF : rsh[15:0];
        if (cs[ACOS_STAGES][0])
        begin
            ang_c = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_ang_reg  <= ang_c;
            fin_zero_reg <= cs[ACOS_STAGES][0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vp_reg    <= 1'b0;
            v1c_reg   <= 1'b0;
            v2c_reg   <= 1'b0;
            v3c_reg   <= 1'b0;
            fin_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            vp_reg    <= ra_v[32];
            v1c_reg   <= dv_v[32];
            v2c_reg   <= v1c_reg;
            v3c_reg   <= v2c_reg;
            fin_v_reg <= cv[ACOS_STAGES];
        end
    end

    // Output word plus one skid word; the pipeline stalls only when both are held.
    logic        ov_reg;
    logic        sv_reg;
    logic [15:0] oa_reg;
    logic        oz_reg;
    logic [15:0] sa_reg;
    logic        sz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (!sv_reg)
        begin
            if (fin_v_reg)
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_reg <= 1'b1;
                end
                else
                begin
                    sv_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
        else if (out_ready)
        begin
            sv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sv_reg)
        begin
            if (fin_v_reg && (!ov_reg || out_ready))
            begin
                oa_reg <= fin_ang_reg;
                oz_reg <= fin_zero_reg;
            end
            else if (fin_v_reg)
            begin
                sa_reg <= fin_ang_reg;
                sz_reg <= fin_zero_reg;
            end
        end
        else if (out_ready)
        begin
            oa_reg <= sa_reg;
            oz_reg <= sz_reg;
        end
    end

    assign in_ready    = !sv_reg;
    assign out_valid   = ov_reg;
    assign angle_deg   = oa_reg;
    assign zero_vector = oz_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        sv_reg |-> ov_reg)
        else $error("skid word held without an output word");

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_vector) |-> (angle_deg == 16'd0))
        else $error("zero-length vector with nonzero angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(angle_deg) <= 32'(ANG_MAX)))
        else $error("angle beyond 180 degrees");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output word dropped while stalled");

endmodule
